/* design/lre_pkg.sv */
// Package for the LED ring animation engine: mode codes, divider operations,
// controller states, command and status structs and the quarter-wave sine table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lre_pkg;

    // Animation modes; codes above MODE_MOOD render as breathe
    localparam logic [2:0] MODE_BREATHE = 3'd0;
    localparam logic [2:0] MODE_RAINBOW = 3'd1;
    localparam logic [2:0] MODE_SPARKLE = 3'd2;
    localparam logic [2:0] MODE_NIGHT   = 3'd3;
    localparam logic [2:0] MODE_PULSE   = 3'd4;
    localparam logic [2:0] MODE_MOOD    = 3'd5;

    localparam logic [7:0] HUE_RESET = 8'd160;

    // Period lengths and expiry times in ms, and the sine scale divisors
    localparam logic [15:0] BREATHE_MS = 16'd4000;
    localparam logic [15:0] RAINBOW_MS = 16'd2000;
    localparam logic [15:0] MOOD_MS    = 16'd3000;
    localparam logic [15:0] SPARKLE_MS = 16'd500;
    localparam logic [31:0] PULSE_MS   = 32'd200;
    localparam logic [15:0] SINE_SPAN  = 16'd65534;
    localparam logic [15:0] SINE_FULL  = 16'd32767;

    // Reciprocals floor(2^32 / d) of the fixed divisors
    localparam logic [63:0] TWO_POW_32   = 64'd4294967296;
    localparam logic [31:0] BREATHE_RCP  = 32'(TWO_POW_32 / 64'(BREATHE_MS));
    localparam logic [31:0] RAINBOW_RCP  = 32'(TWO_POW_32 / 64'(RAINBOW_MS));
    localparam logic [31:0] MOOD_RCP     = 32'(TWO_POW_32 / 64'(MOOD_MS));
    localparam logic [31:0] SPARKLE_RCP  = 32'(TWO_POW_32 / 64'(SPARKLE_MS));
    localparam logic [31:0] SPAN_RCP     = 32'(TWO_POW_32 / 64'(SINE_SPAN));
    localparam logic [31:0] FULL_RCP     = 32'(TWO_POW_32 / 64'(SINE_FULL));

    // Operations issued to the datapath, one per sequence step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_MOD4000,
        OP_IDX4000,
        OP_MOD3000,
        OP_IDX3000,
        OP_MOD2000,
        OP_OFF,
        OP_SINE,
        OP_BV,
        OP_MV,
        OP_SEED,
        OP_SPK
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETM,
        ST_CHECK,
        ST_GO,
        ST_WAIT,
        ST_EMIT,
        ST_FINAL
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic set_mode;
        logic frame_start;
        logic div_start;
        logic sine_load;
        logic pix_clear;
        logic pix_load;
        logic finish;
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic       early;
        logic       div_done;
        logic       out_free;
        logic       pix_last;
        logic [2:0] mode;
    } dp_status_t;

    // Operation sequence of each mode
    function automatic op_t op_for(logic [2:0] mode, logic [2:0] step);
        op_t op;
        op = OP_NONE;
        unique case (mode)
            MODE_RAINBOW:
            begin
                if (step == 3'd0) op = OP_MOD2000;
                else if (step == 3'd1) op = OP_OFF;
            end
            MODE_SPARKLE:
            begin
                if (step == 3'd0) op = OP_SEED;
                else if (step == 3'd1) op = OP_SPK;
            end
            MODE_NIGHT, MODE_PULSE:
            begin
                op = OP_NONE;
            end
            MODE_MOOD:
            begin
                case (step)
                    3'd0:    op = OP_MOD3000;
                    3'd1:    op = OP_IDX3000;
                    3'd2:    op = OP_SINE;
                    3'd3:    op = OP_MV;
                    default: op = OP_NONE;
                endcase
            end
            default:
            begin
                case (step)
                    3'd0:    op = OP_MOD4000;
                    3'd1:    op = OP_IDX4000;
                    3'd2:    op = OP_SINE;
                    3'd3:    op = OP_BV;
                    default: op = OP_NONE;
                endcase
            end
        endcase
        return op;
    endfunction

    // Quarter-wave sine, Q30 Taylor series truncated at each step
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    typedef logic [63:0] tdiv_t [10];
    localparam tdiv_t TAYLOR_DIV = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                     64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    function automatic logic [14:0] quarter_sine(int k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        if (k == 0) return 15'd0;
        if (k >= 256) return 15'd32767;
        x = (HALF_PI_Q30 * 64'(k)) / 64'd256;
        x2 = (x * x) >> 30;
        term = x;
        sum = $signed(x);
        for (int n = 1; n <= 10; n++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n - 1];
            if (n % 2 == 1) sum = sum - $signed(term);
            else sum = sum + $signed(term);
        end
        if (sum < 0) sum = 0;
        r = ($unsigned(sum) * 64'd32767) >> 30;
        if (r > 64'd32767) r = 64'd32767;
        return r[14:0];
    endfunction

    typedef logic [14:0] qtab_t [257];

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int k = 0; k < 257; k++) t[k] = quarter_sine(k);
        return t;
    endfunction

    localparam qtab_t QTAB = build_qtab();

endpackage
`default_nettype wire

/* design/lre_div.sv */
// Divider by a constant: reciprocal multiply, back-multiply and one correction.
// The caller supplies floor(2^32 / den), or all ones for den of one. No package.
`timescale 1ns / 1ps
`default_nettype none
module lre_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] num,
    input  wire logic [15:0] den,
    input  wire logic [31:0] rcp,
    output logic             done,
    output logic [31:0]      quo,
    output logic [15:0]      rem
);
    logic [31:0] num_reg;
    logic [15:0] den_reg;
    logic [31:0] rcp_reg;
    logic [31:0] prod_reg;
    logic [31:0] q0_reg;
    logic [31:0] r0_reg;
    logic        v1_reg;
    logic        v2_reg;
    logic        done_reg;
    logic [63:0] prod_next;
    logic [31:0] qd;
    logic [31:0] r0_next;
    logic        fix;
    logic [31:0] r1;

    // Estimate is exact or one low; the remainder decides the fix
    always_comb
    begin
        prod_next = 64'(num_reg) * 64'(rcp_reg);
        qd = prod_reg * {16'b0, den_reg};
        r0_next = num_reg - qd;
        fix = (r0_reg >= {16'b0, den_reg});
        r1 = r0_reg - {16'b0, den_reg};
    end

    // Advance the stage flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    // Capture operands, estimate and first remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rcp_reg <= rcp;
        end
        if (v1_reg) prod_reg <= prod_next[63:32];
        if (v2_reg)
        begin
            q0_reg <= prod_reg;
            r0_reg <= r0_next;
        end
    end

    assign done = done_reg;
    assign quo = fix ? q0_reg + 32'd1 : q0_reg;
    assign rem = fix ? r1[15:0] : r0_reg[15:0];
endmodule
`default_nettype wire

/* design/lre_datapath.sv */
// Datapath: mode state, frame timing, divider operands, sine lookup and
// pixel output register. Uses lre_pkg and lre_div.
`timescale 1ns / 1ps
`default_nettype none
module lre_datapath #(
    parameter int PIXELS   = 16,
    parameter int FRAME_MS = 100
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lre_pkg::dp_cmd_t cmd,
    output lre_pkg::dp_status_t status,
    input  wire logic [31:0]    now_ms,
    input  wire logic [2:0]     new_mode,
    input  wire logic [7:0]     new_hue,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [5:0]          pixel_index,
    output logic                color_space,
    output logic [7:0]          comp_a,
    output logic [7:0]          comp_b,
    output logic [7:0]          comp_c,
    output logic                frame_end
);
    localparam logic [7:0] HSTEP = 8'(255 / PIXELS);
    localparam logic [6:0] HREM  = 7'(255 % PIXELS);
    localparam logic [6:0] NPIX  = 7'(PIXELS);
    localparam logic [5:0] PLAST = 6'(PIXELS - 1);
    localparam logic [15:0] FMS  = 16'(FRAME_MS);
    localparam logic [31:0] FMS_RCP = (FRAME_MS == 1) ? 32'hFFFF_FFFF
                                    : 32'(lre_pkg::TWO_POW_32 / 64'(FRAME_MS));

    logic [2:0]  mode_reg;
    logic [7:0]  hue_reg;
    logic [31:0] start_reg;
    logic [31:0] last_reg;
    logic [31:0] now_reg;
    logic [2:0]  nmode_reg;
    logic [7:0]  nhue_reg;
    logic [31:0] e_reg;
    logic [11:0] r_reg;
    logic [9:0]  idx_reg;
    logic [7:0]  off_reg;
    logic [7:0]  val_reg;
    logic        seed_reg;
    logic signed [15:0] s_reg;
    logic [5:0]  p_reg;
    logic [7:0]  hq_reg;
    logic [6:0]  hr_reg;

    logic        out_valid_reg;
    logic [5:0]  pix_reg;
    logic        space_reg;
    logic [7:0]  a_reg, b_reg, c_reg;
    logic        end_reg;

    logic [31:0] div_num;
    logic [15:0] div_den;
    logic [31:0] div_rcp;
    logic        div_done;
    logic [31:0] div_quo;
    logic [15:0] div_rem;

    logic [8:0]  kq;
    logic [14:0] mag;
    logic signed [15:0] s_next;
    logic [16:0] sp;
    logic signed [31:0] s_ext;
    logic signed [31:0] mv;
    logic [19:0] r255;
    logic [6:0]  hr_sum;
    logic        space_n;
    logic [7:0]  a_n, b_n, c_n;
    logic        spk_on;

    lre_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .rcp   (div_rcp),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // Divider operands per operation
    always_comb
    begin
        sp = 17'($signed({s_reg[15], s_reg}) + 17'sd32767);
        s_ext = 32'(s_reg);
        mv = s_ext * 32'sd80 + 32'sd3932040;
        r255 = {r_reg, 8'b0} - {8'b0, r_reg};
        div_num = '0;
        div_den = 16'd1;
        div_rcp = 32'hFFFF_FFFF;
        case (cmd.op)
            lre_pkg::OP_MOD4000:
            begin
                div_num = e_reg;
                div_den = lre_pkg::BREATHE_MS;
                div_rcp = lre_pkg::BREATHE_RCP;
            end
            lre_pkg::OP_IDX4000:
            begin
                div_num = {10'b0, r_reg, 10'b0};
                div_den = lre_pkg::BREATHE_MS;
                div_rcp = lre_pkg::BREATHE_RCP;
            end
            lre_pkg::OP_MOD3000:
            begin
                div_num = e_reg;
                div_den = lre_pkg::MOOD_MS;
                div_rcp = lre_pkg::MOOD_RCP;
            end
            lre_pkg::OP_IDX3000:
            begin
                div_num = {10'b0, r_reg, 10'b0};
                div_den = lre_pkg::MOOD_MS;
                div_rcp = lre_pkg::MOOD_RCP;
            end
            lre_pkg::OP_MOD2000:
            begin
                div_num = e_reg;
                div_den = lre_pkg::RAINBOW_MS;
                div_rcp = lre_pkg::RAINBOW_RCP;
            end
            lre_pkg::OP_OFF:
            begin
                div_num = {12'b0, r255};
                div_den = lre_pkg::RAINBOW_MS;
                div_rcp = lre_pkg::RAINBOW_RCP;
            end
            lre_pkg::OP_BV:
            begin
                div_num = 32'({sp, 8'b0}) - 32'(sp);
                div_den = lre_pkg::SINE_SPAN;
                div_rcp = lre_pkg::SPAN_RCP;
            end
            lre_pkg::OP_MV:
            begin
                div_num = $unsigned(mv);
                div_den = lre_pkg::SINE_FULL;
                div_rcp = lre_pkg::FULL_RCP;
            end
            lre_pkg::OP_SEED:
            begin
                div_num = now_reg;
                div_den = FMS;
                div_rcp = FMS_RCP;
            end
            lre_pkg::OP_SPK:
            begin
                div_num = {e_reg[23:0], 8'b0} - e_reg;
                div_den = lre_pkg::SPARKLE_MS;
                div_rcp = lre_pkg::SPARKLE_RCP;
            end
            default: ;
        endcase
    end

    // Sine lookup from the quarter-wave table
    always_comb
    begin
        kq = idx_reg[8] ? (9'd256 - {1'b0, idx_reg[7:0]}) : {1'b0, idx_reg[7:0]};
        mag = lre_pkg::QTAB[kq];
        s_next = idx_reg[9] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    // Pixel color for the current counter
    always_comb
    begin
        spk_on = seed_reg ^ p_reg[0];
        space_n = 1'b1;
        a_n = hue_reg;
        b_n = 8'd255;
        c_n = val_reg;
        unique case (mode_reg)
            lre_pkg::MODE_RAINBOW:
            begin
                a_n = off_reg + hq_reg;
                c_n = 8'd200;
            end
            lre_pkg::MODE_SPARKLE:
            begin
                space_n = 1'b0;
                a_n = spk_on ? val_reg : 8'd0;
                b_n = a_n;
                c_n = a_n;
            end
            lre_pkg::MODE_NIGHT:
            begin
                space_n = 1'b0;
                a_n = 8'd255;
                b_n = 8'd100;
                c_n = 8'd20;
            end
            lre_pkg::MODE_PULSE:
            begin
                space_n = 1'b0;
                a_n = (e_reg < lre_pkg::PULSE_MS) ? 8'd255 : 8'd0;
                b_n = a_n;
                c_n = a_n;
            end
            lre_pkg::MODE_MOOD:
            begin
                b_n = 8'd220;
            end
            default: ;
        endcase
        hr_sum = hr_reg + HREM;
    end

    // Mode state and timing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= lre_pkg::MODE_BREATHE;
            hue_reg <= lre_pkg::HUE_RESET;
            start_reg <= '0;
            last_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_mode && (nmode_reg != mode_reg || nhue_reg != hue_reg))
            begin
                mode_reg <= nmode_reg;
                hue_reg <= nhue_reg;
                start_reg <= now_reg;
            end
            if (cmd.frame_start) last_reg <= now_reg;
            if (cmd.finish &&
                ((mode_reg == lre_pkg::MODE_SPARKLE && e_reg >= 32'(lre_pkg::SPARKLE_MS)) ||
                 (mode_reg == lre_pkg::MODE_PULSE && e_reg >= lre_pkg::PULSE_MS)))
            begin
                mode_reg <= lre_pkg::MODE_BREATHE;
                start_reg <= now_reg;
            end
            if (cmd.pix_load) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    // Request capture, divider results and pixel counters
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg <= now_ms;
            nmode_reg <= new_mode;
            nhue_reg <= new_hue;
        end
        if (cmd.frame_start) e_reg <= now_reg - start_reg;
        if (cmd.sine_load) s_reg <= s_next;
        if (div_done)
        begin
            case (cmd.op)
                lre_pkg::OP_MOD4000, lre_pkg::OP_MOD3000, lre_pkg::OP_MOD2000:
                    r_reg <= div_rem[11:0];
                lre_pkg::OP_IDX4000, lre_pkg::OP_IDX3000: idx_reg <= div_quo[9:0];
                lre_pkg::OP_OFF: off_reg <= div_quo[7:0];
                lre_pkg::OP_BV, lre_pkg::OP_MV: val_reg <= div_quo[7:0];
                lre_pkg::OP_SEED: seed_reg <= ~div_quo[0];
                lre_pkg::OP_SPK:
                    val_reg <= (e_reg >= 32'(lre_pkg::SPARKLE_MS)) ? 8'd0
                                                                 : 8'd255 - div_quo[7:0];
                default: ;
            endcase
        end
        if (cmd.pix_clear)
        begin
            p_reg <= '0;
            hq_reg <= '0;
            hr_reg <= '0;
        end
        else if (cmd.pix_load)
        begin
            p_reg <= p_reg + 6'd1;
            if (hr_sum >= NPIX)
            begin
                hr_reg <= hr_sum - NPIX;
                hq_reg <= hq_reg + HSTEP + 8'd1;
            end
            else
            begin
                hr_reg <= hr_sum;
                hq_reg <= hq_reg + HSTEP;
            end
        end
        if (cmd.pix_load)
        begin
            pix_reg <= p_reg;
            space_reg <= space_n;
            a_reg <= a_n;
            b_reg <= b_n;
            c_reg <= c_n;
            end_reg <= (p_reg == PLAST);
        end
    end

    always_comb
    begin
        status.early = (now_reg - last_reg) < 32'(FRAME_MS);
        status.div_done = div_done;
        status.out_free = !out_valid_reg || out_ready;
        status.pix_last = (p_reg == PLAST);
        status.mode = mode_reg;
    end

    assign out_valid = out_valid_reg;
    assign pixel_index = pix_reg;
    assign color_space = space_reg;
    assign comp_a = a_reg;
    assign comp_b = b_reg;
    assign comp_c = c_reg;
    assign frame_end = end_reg;
endmodule
`default_nettype wire

/* design/lre_ctrl.sv */
// Controller state machine: accepts requests, sequences divider and sine
// operations per mode, then emits one pixel per free output slot. Uses lre_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lre_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              action,
    input  wire lre_pkg::dp_status_t status,
    output lre_pkg::dp_cmd_t       cmd
);
    lre_pkg::ctrl_state_t state_reg, state_next;
    logic [2:0] step_reg, step_next;
    lre_pkg::op_t op;

    assign op = lre_pkg::op_for(status.mode, step_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        unique case (state_reg)
            lre_pkg::ST_IDLE:
                if (in_valid) state_next = action ? lre_pkg::ST_SETM : lre_pkg::ST_CHECK;
            lre_pkg::ST_SETM:
                state_next = lre_pkg::ST_IDLE;
            lre_pkg::ST_CHECK:
            begin
                step_next = '0;
                state_next = status.early ? lre_pkg::ST_IDLE : lre_pkg::ST_GO;
            end
            lre_pkg::ST_GO:
            begin
                if (op == lre_pkg::OP_NONE) state_next = lre_pkg::ST_EMIT;
                else if (op == lre_pkg::OP_SINE) step_next = step_reg + 3'd1;
                else state_next = lre_pkg::ST_WAIT;
            end
            lre_pkg::ST_WAIT:
                if (status.div_done)
                begin
                    step_next = step_reg + 3'd1;
                    state_next = lre_pkg::ST_GO;
                end
            lre_pkg::ST_EMIT:
                if (status.out_free && status.pix_last) state_next = lre_pkg::ST_FINAL;
            lre_pkg::ST_FINAL:
                state_next = lre_pkg::ST_IDLE;
            default:
                state_next = lre_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd = '0;
        cmd.op = op;
        in_ready = 1'b0;
        unique case (state_reg)
            lre_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            lre_pkg::ST_SETM:  cmd.set_mode = 1'b1;
            lre_pkg::ST_CHECK: cmd.frame_start = !status.early;
            lre_pkg::ST_GO:
            begin
                cmd.pix_clear = (op == lre_pkg::OP_NONE);
                cmd.sine_load = (op == lre_pkg::OP_SINE);
                cmd.div_start = (op != lre_pkg::OP_NONE) && (op != lre_pkg::OP_SINE);
            end
            lre_pkg::ST_WAIT:  ;
            lre_pkg::ST_EMIT:  cmd.pix_load = status.out_free;
            lre_pkg::ST_FINAL: cmd.finish = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lre_pkg::ST_IDLE;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
        end
    end
endmodule
`default_nettype wire

/* design/led_ring_animation_engine.sv */
// LED ring animation engine, top level.
// Set-mode requests and early ticks return to idle without rendering. A rendered
// tick runs three divisions and a sine step for breathe and mood, two divisions
// for rainbow and sparkle and none for nightlight and pulse, then emits PIXELS
// pixels; a full output register with out_ready low stalls the pixel stream.
// One request at a time. Reset (rst_n low, asynchronous): breathe mode, hue 160,
// mode clock and last frame time at 0, output empty.
`timescale 1ns / 1ps
`default_nettype none
module led_ring_animation_engine #(
    parameter int PIXELS   = 16,
    parameter int FRAME_MS = 100
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        action,
    input  wire logic [31:0] now_ms,
    input  wire logic [2:0]  new_mode,
    input  wire logic [7:0]  new_hue,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [5:0]       pixel_index,
    output logic             color_space,
    output logic [7:0]       comp_a,
    output logic [7:0]       comp_b,
    output logic [7:0]       comp_c,
    output logic             frame_end
);
    lre_pkg::dp_cmd_t    cmd;
    lre_pkg::dp_status_t status;

    lre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .status   (status),
        .cmd      (cmd)
    );

    lre_datapath #(
        .PIXELS   (PIXELS),
        .FRAME_MS (FRAME_MS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .now_ms      (now_ms),
        .new_mode    (new_mode),
        .new_hue     (new_hue),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_index (pixel_index),
        .color_space (color_space),
        .comp_a      (comp_a),
        .comp_b      (comp_b),
        .comp_c      (comp_c),
        .frame_end   (frame_end)
    );
endmodule
`default_nettype wire
